[design/per_class_greedy_nms_top_assert.svh]
// Assertion macros for the port checker of the suppression block.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef PER_CLASS_GREEDY_NMS_TOP_ASSERT_SVH
`define PER_CLASS_GREEDY_NMS_TOP_ASSERT_SVH

// same-cycle implication
`define NMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/nms_pkg.sv]
// Shared constants, types and controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package nms_pkg;
	localparam int MAX_BOXES  = 64;
	localparam int COORD_BITS = 12;
	localparam int SCORE_W    = 16;
	localparam int CLASS_W    = 8;
	localparam int THR_W      = 7;
	localparam int IDX_W      = $clog2(MAX_BOXES);
	localparam int CNT_W      = $clog2(MAX_BOXES + 1);
	localparam int NCLASS     = 1 << CLASS_W;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(50);
	localparam int IOU_PCT    = 100;
	localparam int PCT_W      = 8;
	localparam int DIFF_W     = COORD_BITS + 2;
	localparam int AREA_W     = 2 * DIFF_W;
	localparam int UNI_W      = AREA_W + 2;
	localparam int CMP_W      = UNI_W + PCT_W + 1;

	typedef struct packed {
		logic [CLASS_W-1:0]    cls;
		logic [SCORE_W-1:0]    score;
		logic [COORD_BITS-1:0] max_y;
		logic [COORD_BITS-1:0] max_x;
		logic [COORD_BITS-1:0] min_y;
		logic [COORD_BITS-1:0] min_x;
	} box_t;

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [SCORE_W-1:0] score;
	} sort_ent_t;

	localparam int BOX_W  = $bits(box_t);
	localparam int SORT_W = $bits(sort_ent_t);

	typedef enum logic {BSEL_SCAN, BSEL_SORT} box_sel_t;
	typedef enum logic {WSEL_GATHER, WSEL_HOLD} sort_wsel_t;

	typedef struct packed {
		logic             load;
		logic             clear;
		logic             class_re;
		logic [IDX_W-1:0] class_raddr;
		logic             class_latch;
		logic             box_re;
		box_sel_t         box_sel;
		logic [IDX_W-1:0] scan_addr;
		logic             sort_re;
		logic [IDX_W-1:0] sort_raddr;
		logic             sort_we;
		logic [IDX_W-1:0] sort_waddr;
		sort_wsel_t       sort_wsel;
		logic             hold_load;
		logic             latch_p;
		logic             latch_q;
		logic             iou_start;
		logic             rm_q;
		logic             emit;
		logic             flush;
	} nms_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] box_count;
		logic [CNT_W-1:0] class_count;
		logic             class_match;
		logic             swap_need;
		logic             sort_removed;
		logic             iou_done;
		logic             iou_hit;
		logic             pend_valid;
		logic             out_free;
	} nms_stat_t;
endpackage

[design/per_class_greedy_nms_top.sv]
// Top level of per-class greedy NMS: controller plus datapath.
// Depends on nms_pkg, nms_ctrl, nms_dp (and nms_ram through nms_dp).
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  in      | in_valid / in_stall | min_x min_y max_x max_y score class_id last_in
//  out     | out_valid/out_stall | out_min_x .. out_class last_out
//  cfg     | cfg_valid/cfg_ready | iou_threshold (7 bit, reset 50)
//
// Boxes load one per cycle while idle; the transaction with last_in starts the frame.
// Per class: a class scan over every stored box, an exchange sort, then IoU pairs
// one at a time through the 4-stage IoU pipeline, an emit per kept box, frame end.
// The box store has a single read port; every access in those loops goes through it.
// Reset clears counts and removed flags at once; no clearing pass.
// in_stall is high for the whole frame; out_stall holds output, can stall emit/FIN.
`timescale 1ns / 1ps

module per_class_greedy_nms_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [nms_pkg::COORD_BITS-1:0] min_x,
	input  logic [nms_pkg::COORD_BITS-1:0] min_y,
	input  logic [nms_pkg::COORD_BITS-1:0] max_x,
	input  logic [nms_pkg::COORD_BITS-1:0] max_y,
	input  logic [nms_pkg::SCORE_W-1:0]    score,
	input  logic [nms_pkg::CLASS_W-1:0]    class_id,
	input  logic                          last_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [nms_pkg::COORD_BITS-1:0] out_min_x,
	output logic [nms_pkg::COORD_BITS-1:0] out_min_y,
	output logic [nms_pkg::COORD_BITS-1:0] out_max_x,
	output logic [nms_pkg::COORD_BITS-1:0] out_max_y,
	output logic [nms_pkg::SCORE_W-1:0]    out_score,
	output logic [nms_pkg::CLASS_W-1:0]    out_class,
	output logic                          last_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nms_pkg::THR_W-1:0]      iou_threshold
);
	import nms_pkg::*;

	nms_cmd_t  cmd;
	nms_stat_t stat;

	assign cfg_ready = 1'b1;

	nms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .last_in(last_in),
		.in_stall(in_stall), .stat(stat), .cmd(cmd)
	);

	nms_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.min_x(min_x), .min_y(min_y), .max_x(max_x), .max_y(max_y),
		.score(score), .class_id(class_id),
		.cfg_valid(cfg_valid && cfg_ready), .iou_threshold(iou_threshold),
		.out_stall(out_stall), .out_valid(out_valid),
		.out_min_x(out_min_x), .out_min_y(out_min_y),
		.out_max_x(out_max_x), .out_max_y(out_max_y),
		.out_score(out_score), .out_class(out_class), .last_out(last_out)
	);
endmodule

[design/nms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

[design/nms_dp.sv]
// Datapath: box, class-order and sort stores, removed flags, IoU pipeline,
// pending and output registers. Depends on nms_pkg and nms_ram.
`timescale 1ns / 1ps

module nms_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nms_pkg::nms_cmd_t             cmd,
	output nms_pkg::nms_stat_t            stat,
	input  logic [nms_pkg::COORD_BITS-1:0] min_x,
	input  logic [nms_pkg::COORD_BITS-1:0] min_y,
	input  logic [nms_pkg::COORD_BITS-1:0] max_x,
	input  logic [nms_pkg::COORD_BITS-1:0] max_y,
	input  logic [nms_pkg::SCORE_W-1:0]    score,
	input  logic [nms_pkg::CLASS_W-1:0]    class_id,
	input  logic                          cfg_valid,
	input  logic [nms_pkg::THR_W-1:0]      iou_threshold,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [nms_pkg::COORD_BITS-1:0] out_min_x,
	output logic [nms_pkg::COORD_BITS-1:0] out_min_y,
	output logic [nms_pkg::COORD_BITS-1:0] out_max_x,
	output logic [nms_pkg::COORD_BITS-1:0] out_max_y,
	output logic [nms_pkg::SCORE_W-1:0]    out_score,
	output logic [nms_pkg::CLASS_W-1:0]    out_class,
	output logic                          last_out
);
	import nms_pkg::*;

	localparam logic signed [PCT_W:0] PCT_S = (PCT_W + 1)'(IOU_PCT);

	logic [CNT_W-1:0]     box_count_q, class_count_q;
	logic [NCLASS-1:0]    seen_q;
	logic [MAX_BOXES-1:0] removed_q;
	logic [THR_W-1:0]     thr_q;
	logic [CLASS_W-1:0]   cur_class_q;
	sort_ent_t            hold_q;
	box_t                 p_q, pend_q, out_q;
	logic [IDX_W-1:0]     q_idx_q;
	logic                 pend_valid_q, out_valid_q, out_last_q;

	box_t                 new_box, box_rd;
	sort_ent_t            sort_rd, sort_wdata;
	logic [CLASS_W-1:0]   class_rd;
	logic                 store, all_zero, new_class, load_out, out_free;
	logic [IDX_W-1:0]     box_raddr;

	function automatic logic signed [DIFF_W-1:0] span(
		input logic [COORD_BITS-1:0] lo,
		input logic [COORD_BITS-1:0] hi
	);
		return DIFF_W'(hi) - DIFF_W'(lo) + DIFF_W'(1);
	endfunction

	assign new_box   = '{cls: class_id, score: score, max_y: max_y, max_x: max_x,
		min_y: min_y, min_x: min_x};
	assign store     = cmd.load && (box_count_q != CNT_W'(MAX_BOXES));
	assign all_zero  = (score == '0) && (min_x == '0) && (min_y == '0) &&
		(max_x == '0) && (max_y == '0);
	assign new_class = store && !seen_q[class_id];
	assign box_raddr = (cmd.box_sel == BSEL_SORT) ? sort_rd.idx : cmd.scan_addr;
	assign sort_wdata = (cmd.sort_wsel == WSEL_HOLD) ? hold_q :
		'{idx: cmd.scan_addr, score: box_rd.score};

	nms_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
		.clk(clk), .we(store), .waddr(box_count_q[IDX_W-1:0]), .wdata(new_box),
		.re(cmd.box_re), .raddr(box_raddr), .rdata(box_rd)
	);

	nms_ram #(.WIDTH(CLASS_W), .DEPTH(MAX_BOXES)) u_class_ram (
		.clk(clk), .we(new_class), .waddr(class_count_q[IDX_W-1:0]), .wdata(class_id),
		.re(cmd.class_re), .raddr(cmd.class_raddr), .rdata(class_rd)
	);

	nms_ram #(.WIDTH(SORT_W), .DEPTH(MAX_BOXES)) u_sort_ram (
		.clk(clk), .we(cmd.sort_we), .waddr(cmd.sort_waddr), .wdata(sort_wdata),
		.re(cmd.sort_re), .raddr(cmd.sort_raddr), .rdata(sort_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count_q   <= '0;
			class_count_q <= '0;
			seen_q        <= '0;
			removed_q     <= '0;
			thr_q         <= THR_RESET;
		end else begin
			if (cfg_valid)
				thr_q <= iou_threshold;
			if (cmd.clear) begin
				box_count_q   <= '0;
				class_count_q <= '0;
				seen_q        <= '0;
				removed_q     <= '0;
			end else begin
				if (store) begin
					box_count_q <= box_count_q + CNT_W'(1);
					removed_q[box_count_q[IDX_W-1:0]] <= all_zero;
				end
				if (new_class) begin
					class_count_q    <= class_count_q + CNT_W'(1);
					seen_q[class_id] <= 1'b1;
				end
				if (cmd.rm_q)
					removed_q[q_idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.class_latch)
			cur_class_q <= class_rd;
		if (cmd.hold_load)
			hold_q <= sort_rd;
		if (cmd.latch_p)
			p_q <= box_rd;
		if (cmd.latch_q)
			q_idx_q <= sort_rd.idx;
	end

	// IoU pipeline: spans, products, union, scaled compare.
	// floor(inter*100/uni) > thr  <=>  inter*100 >= (thr+1)*uni
	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0] wa_s1, ha_s1, wb_s1, hb_s1, wi_s1, hi_s1;
	logic                     ovl_s1, ovl_s2, ok_s3, ok_s4;
	logic signed [AREA_W-1:0] area_a_s2, area_b_s2, inter_s2, inter_s3;
	logic signed [UNI_W-1:0]  uni_s3;
	logic signed [CMP_W-1:0]  lhs_s4, rhs_s4;
	logic [COORD_BITS-1:0]    ix0, iy0, ix1, iy1;
	logic                     ovl;
	logic signed [PCT_W:0]    thr_p1;

	assign ix0 = (p_q.min_x > box_rd.min_x) ? p_q.min_x : box_rd.min_x;
	assign iy0 = (p_q.min_y > box_rd.min_y) ? p_q.min_y : box_rd.min_y;
	assign ix1 = (p_q.max_x < box_rd.max_x) ? p_q.max_x : box_rd.max_x;
	assign iy1 = (p_q.max_y < box_rd.max_y) ? p_q.max_y : box_rd.max_y;
	assign ovl = (p_q.max_x > box_rd.min_x) && (p_q.max_y > box_rd.min_y) &&
		(box_rd.max_x > p_q.min_x) && (box_rd.max_y > p_q.min_y);
	assign thr_p1 = $signed({1'b0, PCT_W'(thr_q) + PCT_W'(1)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.iou_start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		wa_s1     <= span(p_q.min_x, p_q.max_x);
		ha_s1     <= span(p_q.min_y, p_q.max_y);
		wb_s1     <= span(box_rd.min_x, box_rd.max_x);
		hb_s1     <= span(box_rd.min_y, box_rd.max_y);
		wi_s1     <= span(ix0, ix1);
		hi_s1     <= span(iy0, iy1);
		ovl_s1    <= ovl;
		area_a_s2 <= AREA_W'(wa_s1) * AREA_W'(ha_s1);
		area_b_s2 <= AREA_W'(wb_s1) * AREA_W'(hb_s1);
		inter_s2  <= AREA_W'(wi_s1) * AREA_W'(hi_s1);
		ovl_s2    <= ovl_s1;
		uni_s3    <= UNI_W'(area_a_s2) + UNI_W'(area_b_s2) - UNI_W'(inter_s2);
		inter_s3  <= inter_s2;
		ok_s3     <= ovl_s2 && (inter_s2 > 0);
		lhs_s4    <= CMP_W'(inter_s3) * CMP_W'(PCT_S);
		rhs_s4    <= CMP_W'(uni_s3) * CMP_W'(thr_p1);
		ok_s4     <= ok_s3 && (uni_s3 > 0);
	end

	// pending kept box is held back so the frame's final one can carry last_out
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (cmd.emit || cmd.flush) && pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.emit)
				pend_valid_q <= 1'b1;
			else if (cmd.flush)
				pend_valid_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q      <= pend_q;
			out_last_q <= cmd.flush;
		end
		if (cmd.emit)
			pend_q <= p_q;
	end

	assign stat.box_count    = box_count_q;
	assign stat.class_count  = class_count_q;
	assign stat.class_match  = (box_rd.cls == cur_class_q);
	assign stat.swap_need    = (hold_q.score < sort_rd.score);
	assign stat.sort_removed = removed_q[sort_rd.idx];
	assign stat.iou_done     = v_s4;
	assign stat.iou_hit      = ok_s4 && (lhs_s4 >= rhs_s4);
	assign stat.pend_valid   = pend_valid_q;
	assign stat.out_free     = out_free;

	assign out_valid = out_valid_q;
	assign out_min_x = out_q.min_x;
	assign out_min_y = out_q.min_y;
	assign out_max_x = out_q.max_x;
	assign out_max_y = out_q.max_y;
	assign out_score = out_q.score;
	assign out_class = out_q.cls;
	assign last_out  = out_last_q;
endmodule

[design/nms_ctrl.sv]
// Controller: frame sequencing over classes, gather, exchange sort and
// greedy suppression loops. Depends on nms_pkg.
`timescale 1ns / 1ps

module nms_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last_in,
	output logic               in_stall,
	input  nms_pkg::nms_stat_t stat,
	output nms_pkg::nms_cmd_t  cmd
);
	import nms_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLS_RD, ST_CLS_LD, ST_G_RD, ST_G_CHK,
		ST_S_LDI, ST_S_HOLD, ST_S_RDJ, ST_S_CMP, ST_S_WRI,
		ST_P_RDI, ST_P_CHK, ST_P_LD, ST_Q_RDJ, ST_Q_CHK,
		ST_Q_IOU, ST_Q_WAIT, ST_EMIT, ST_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] c_q, k_q, n_q, i_q, j_q;
	logic [CNT_W-1:0] i_inc, j_inc;
	logic             i_last, sort_done, out_ok;

	assign i_inc     = i_q + CNT_W'(1);
	assign j_inc     = j_q + CNT_W'(1);
	assign i_last    = (i_inc == n_q);
	assign sort_done = ({1'b0, i_q} + (CNT_W + 1)'(2)) >= {1'b0, n_q};
	assign out_ok    = !stat.pend_valid || stat.out_free;
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		cmd             = '0;
		cmd.class_raddr = c_q[IDX_W-1:0];
		cmd.scan_addr   = k_q[IDX_W-1:0];
		cmd.sort_raddr  = i_q[IDX_W-1:0];
		cmd.sort_waddr  = i_q[IDX_W-1:0];
		cmd.box_sel     = BSEL_SCAN;
		cmd.sort_wsel   = WSEL_HOLD;
		unique case (state_q)
			ST_IDLE:   cmd.load = in_valid;
			ST_CLS_RD: cmd.class_re = (c_q != stat.class_count);
			ST_CLS_LD: cmd.class_latch = 1'b1;
			ST_G_RD:   cmd.box_re = (k_q != stat.box_count);
			ST_G_CHK: begin
				cmd.sort_we    = stat.class_match;
				cmd.sort_waddr = n_q[IDX_W-1:0];
				cmd.sort_wsel  = WSEL_GATHER;
			end
			ST_S_LDI:  cmd.sort_re = 1'b1;
			ST_S_HOLD: cmd.hold_load = 1'b1;
			ST_S_RDJ: begin
				cmd.sort_re    = 1'b1;
				cmd.sort_raddr = j_q[IDX_W-1:0];
			end
			ST_S_CMP: begin
				cmd.sort_we    = stat.swap_need;
				cmd.sort_waddr = j_q[IDX_W-1:0];
				cmd.hold_load  = stat.swap_need;
			end
			ST_S_WRI:  cmd.sort_we = 1'b1;
			ST_P_RDI:  cmd.sort_re = 1'b1;
			ST_P_CHK: begin
				cmd.box_re  = !stat.sort_removed;
				cmd.box_sel = BSEL_SORT;
			end
			ST_P_LD:   cmd.latch_p = 1'b1;
			ST_Q_RDJ: begin
				cmd.sort_re    = (j_q != n_q);
				cmd.sort_raddr = j_q[IDX_W-1:0];
			end
			ST_Q_CHK: begin
				cmd.box_re  = !stat.sort_removed;
				cmd.box_sel = BSEL_SORT;
				cmd.latch_q = !stat.sort_removed;
			end
			ST_Q_IOU:  cmd.iou_start = 1'b1;
			ST_Q_WAIT: cmd.rm_q = stat.iou_done && stat.iou_hit;
			ST_EMIT:   cmd.emit = out_ok;
			ST_FIN: begin
				cmd.flush = out_ok;
				cmd.clear = out_ok;
			end
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			c_q     <= '0;
			k_q     <= '0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid && last_in) begin
					c_q     <= '0;
					state_q <= ST_CLS_RD;
				end
				ST_CLS_RD: state_q <= (c_q == stat.class_count) ? ST_FIN : ST_CLS_LD;
				ST_CLS_LD: begin
					k_q     <= '0;
					n_q     <= '0;
					state_q <= ST_G_RD;
				end
				ST_G_RD: if (k_q == stat.box_count) begin
					i_q <= '0;
					if (n_q >= CNT_W'(2))
						state_q <= ST_S_LDI;
					else if (n_q == CNT_W'(1))
						state_q <= ST_P_RDI;
					else begin
						c_q     <= c_q + CNT_W'(1);
						state_q <= ST_CLS_RD;
					end
				end else begin
					state_q <= ST_G_CHK;
				end
				ST_G_CHK: begin
					if (stat.class_match)
						n_q <= n_q + CNT_W'(1);
					k_q     <= k_q + CNT_W'(1);
					state_q <= ST_G_RD;
				end
				ST_S_LDI:  state_q <= ST_S_HOLD;
				ST_S_HOLD: begin
					j_q     <= i_inc;
					state_q <= ST_S_RDJ;
				end
				ST_S_RDJ:  state_q <= ST_S_CMP;
				ST_S_CMP: begin
					j_q     <= j_inc;
					state_q <= (j_inc == n_q) ? ST_S_WRI : ST_S_RDJ;
				end
				ST_S_WRI: if (sort_done) begin
					i_q     <= '0;
					state_q <= ST_P_RDI;
				end else begin
					i_q     <= i_inc;
					state_q <= ST_S_LDI;
				end
				ST_P_RDI:  state_q <= ST_P_CHK;
				ST_P_CHK: if (!stat.sort_removed) begin
					state_q <= ST_P_LD;
				end else if (i_last) begin
					c_q     <= c_q + CNT_W'(1);
					state_q <= ST_CLS_RD;
				end else begin
					i_q     <= i_inc;
					state_q <= ST_P_RDI;
				end
				ST_P_LD: begin
					j_q     <= i_inc;
					state_q <= ST_Q_RDJ;
				end
				ST_Q_RDJ:  state_q <= (j_q == n_q) ? ST_EMIT : ST_Q_CHK;
				ST_Q_CHK: if (stat.sort_removed) begin
					j_q     <= j_inc;
					state_q <= ST_Q_RDJ;
				end else begin
					state_q <= ST_Q_IOU;
				end
				ST_Q_IOU:  state_q <= ST_Q_WAIT;
				ST_Q_WAIT: if (stat.iou_done) begin
					j_q     <= j_inc;
					state_q <= ST_Q_RDJ;
				end
				ST_EMIT: if (out_ok) begin
					if (i_last) begin
						c_q     <= c_q + CNT_W'(1);
						state_q <= ST_CLS_RD;
					end else begin
						i_q     <= i_inc;
						state_q <= ST_P_RDI;
					end
				end
				ST_FIN: if (out_ok)
					state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[design/nms_checker.sv]
// Port-level checker for per_class_greedy_nms_top, attached by bind.
// Depends on per_class_greedy_nms_top_assert.svh.
`timescale 1ns / 1ps
`include "per_class_greedy_nms_top_assert.svh"

module nms_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_in,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] out_min_x,
	input logic [15:0] out_score,
	input logic        last_out
);
	// a frame-ending transaction must lock out further input
	`NMS_ASSERT_NXT(a_last_busy, clk, arst_n, in_valid && !in_stall && last_in, in_stall, "input not stalled after last_in")
	`NMS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_score) && $stable(out_min_x) && $stable(last_out), "stalled output changed")
	// nothing follows the frame's final result right away
	`NMS_ASSERT_NXT(a_frame_gap, clk, arst_n, out_valid && !out_stall && last_out, !out_valid, "output right after last_out")
endmodule

bind per_class_greedy_nms_top nms_port_checker u_nms_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.last_in(last_in), .out_valid(out_valid), .out_stall(out_stall),
	.out_min_x(out_min_x), .out_score(out_score), .last_out(last_out)
);

[sim/nms_checker.sv]
// Checker for the per-class greedy suppression block: watches the box, kept-box
// and threshold channels, predicts kept boxes per frame and compares them. Uses nms_pkg.
`timescale 1ns / 1ps

module nms_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [nms_pkg::COORD_BITS-1:0] min_x,
	input  logic [nms_pkg::COORD_BITS-1:0] min_y,
	input  logic [nms_pkg::COORD_BITS-1:0] max_x,
	input  logic [nms_pkg::COORD_BITS-1:0] max_y,
	input  logic [nms_pkg::SCORE_W-1:0]    score,
	input  logic [nms_pkg::CLASS_W-1:0]    class_id,
	input  logic                           last_in,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [nms_pkg::COORD_BITS-1:0] out_min_x,
	input  logic [nms_pkg::COORD_BITS-1:0] out_min_y,
	input  logic [nms_pkg::COORD_BITS-1:0] out_max_x,
	input  logic [nms_pkg::COORD_BITS-1:0] out_max_y,
	input  logic [nms_pkg::SCORE_W-1:0]    out_score,
	input  logic [nms_pkg::CLASS_W-1:0]    out_class,
	input  logic                           last_out,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [nms_pkg::THR_W-1:0]      iou_threshold,
	output int                             fail_count,
	output int                             pending_kept
);
	import nms_pkg::*;

	typedef struct {
		box_t b;
		logic lst;
	} kept_t;

	box_t              boxes [MAX_BOXES];
	logic              gone  [MAX_BOXES];
	int                n_boxes;
	logic [CLASS_W-1:0] classes [MAX_BOXES];
	int                n_classes;
	logic [THR_W-1:0]  thr;
	kept_t             kept_q [$];

	assign pending_kept = kept_q.size();

	function automatic longint overlap_pct(box_t a, box_t b);
		longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, inter, uni;
		ax0 = a.min_x; ay0 = a.min_y; ax1 = a.max_x; ay1 = a.max_y;
		bx0 = b.min_x; by0 = b.min_y; bx1 = b.max_x; by1 = b.max_y;
		if (!(ax1 > bx0 && ay1 > by0 && bx1 > ax0 && by1 > ay0))
			return 0;
		inter = ((ax1 < bx1 ? ax1 : bx1) - (ax0 > bx0 ? ax0 : bx0) + 1) *
			((ay1 < by1 ? ay1 : by1) - (ay0 > by0 ? ay0 : by0) + 1);
		uni = (ax1 - ax0 + 1) * (ay1 - ay0 + 1) + (bx1 - bx0 + 1) * (by1 - by0 + 1) - inter;
		if (inter <= 0 || uni <= 0)
			return 0;
		return (inter * 100) / uni;
	endfunction

	task automatic store_box(box_t nb, logic lst);
		bit known;
		int idx[MAX_BOXES];
		int n, t, p, first;
		if (n_boxes < MAX_BOXES) begin
			boxes[n_boxes] = nb;
			gone[n_boxes] = (nb.score == 0 && nb.min_x == 0 && nb.min_y == 0 &&
				nb.max_x == 0 && nb.max_y == 0);
			n_boxes++;
			known = 0;
			for (int i = 0; i < n_classes; i++)
				if (classes[i] == nb.cls) known = 1;
			if (!known) begin
				classes[n_classes] = nb.cls;
				n_classes++;
			end
		end
		if (!lst) return;
		first = kept_q.size();
		for (int c = 0; c < n_classes; c++) begin
			n = 0;
			for (int i = 0; i < n_boxes; i++)
				if (boxes[i].cls == classes[c]) begin
					idx[n] = i;
					n++;
				end
			for (int i = 0; i + 1 < n; i++)
				for (int j = i + 1; j < n; j++)
					if (boxes[idx[i]].score < boxes[idx[j]].score) begin
						t = idx[i]; idx[i] = idx[j]; idx[j] = t;
					end
			for (int i = 0; i < n; i++) begin
				p = idx[i];
				if (gone[p]) continue;
				for (int j = i + 1; j < n; j++)
					if (!gone[idx[j]] && overlap_pct(boxes[p], boxes[idx[j]]) > thr)
						gone[idx[j]] = 1;
				kept_q.insert(kept_q.size(), '{b: boxes[p], lst: 1'b0});
			end
		end
		if (kept_q.size() > first)
			kept_q[kept_q.size() - 1].lst = 1'b1;
		n_boxes = 0;
		n_classes = 0;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		n_boxes = 0;
		n_classes = 0;
		thr = THR_RESET;
	end

	always @(posedge clk) begin
		kept_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				thr = iou_threshold;
			if (in_valid && !in_stall)
				store_box('{cls: class_id, score: score, max_y: max_y, max_x: max_x,
					min_y: min_y, min_x: min_x}, last_in);
			if (out_valid && !out_stall) begin
				if (kept_q.size() == 0) begin
					report_mismatch("unexpected kept box, class", out_class, -1);
				end else begin
					e = kept_q.pop_front();
					if (out_min_x !== e.b.min_x) report_mismatch("min_x", out_min_x, e.b.min_x);
					if (out_min_y !== e.b.min_y) report_mismatch("min_y", out_min_y, e.b.min_y);
					if (out_max_x !== e.b.max_x) report_mismatch("max_x", out_max_x, e.b.max_x);
					if (out_max_y !== e.b.max_y) report_mismatch("max_y", out_max_y, e.b.max_y);
					if (out_score !== e.b.score) report_mismatch("score", out_score, e.b.score);
					if (out_class !== e.b.cls) report_mismatch("class", out_class, e.b.cls);
					if (last_out !== e.lst) report_mismatch("last_out", last_out, e.lst);
				end
			end
		end
	end
endmodule

[sim/tb_top.sv]
// Testbench top for per_class_greedy_nms_top: drives frames of boxes with bursty
// gaps, random output stalls and threshold changes; nms_checker does the checking.
`timescale 1ns / 1ps

module tb_top;
	import nms_pkg::*;

	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, last_in = 0, out_stall = 0, cfg_valid = 0;
	logic [COORD_BITS-1:0] min_x = 0, min_y = 0, max_x = 0, max_y = 0;
	logic [SCORE_W-1:0] score = 0;
	logic [CLASS_W-1:0] class_id = 0;
	logic [THR_W-1:0] iou_threshold = 0;
	logic in_stall, out_valid, last_out, cfg_ready;
	logic [COORD_BITS-1:0] out_min_x, out_min_y, out_max_x, out_max_y;
	logic [SCORE_W-1:0] out_score;
	logic [CLASS_W-1:0] out_class;
	int fail_count, pending_kept;
	longint cycles = 0;
	bit hold_off = 0;
	int stall_pct = 30;

	always #10 clk = ~clk;

	per_class_greedy_nms_top i_dut (.*);
	nms_checker i_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver stall pattern; hold_off forces a long back-pressure stretch
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1;
		else out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_box(box_t b, logic lst);
		in_valid <= 1;
		min_x <= b.min_x; min_y <= b.min_y; max_x <= b.max_x; max_y <= b.max_y;
		score <= b.score; class_id <= b.cls; last_in <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic idle_gap();
		int g;
		g = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_kept != 0 || in_stall) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_thr(logic [THR_W-1:0] v);
		cfg_valid <= 1;
		iou_threshold <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	function automatic box_t rand_box(int ncls, int base_x, int base_y);
		box_t b;
		int w, h;
		w = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1, 200);
		h = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1, 200);
		b.min_x = COORD_BITS'(base_x + $urandom_range(40));
		b.min_y = COORD_BITS'(base_y + $urandom_range(40));
		b.max_x = ((b.min_x + w) > 4095) ? COORD_BITS'(4095) : COORD_BITS'(b.min_x + w);
		b.max_y = ((b.min_y + h) > 4095) ? COORD_BITS'(4095) : COORD_BITS'(b.min_y + h);
		if ($urandom_range(19) == 0) begin
			b.min_x = COORD_BITS'($urandom); b.max_x = COORD_BITS'($urandom);
			b.min_y = COORD_BITS'($urandom); b.max_y = COORD_BITS'($urandom);
		end
		b.score = ($urandom_range(7) == 0) ? SCORE_W'($urandom_range(3) * 16'h5555) :
			SCORE_W'($urandom);
		b.cls = ($urandom_range(15) == 0) ? CLASS_W'($urandom) :
			CLASS_W'($urandom_range(ncls - 1));
		return b;
	endfunction

	task automatic random_frame(int nb);
		int ncls, bx, by;
		box_t b;
		ncls = $urandom_range(1, 4);
		bx = $urandom_range(3800);
		by = $urandom_range(3800);
		for (int i = 0; i < nb; i++) begin
			b = rand_box(ncls, bx, by);
			if ($urandom_range(29) == 0) b = '0;
			send_box(b, i == nb - 1);
			idle_gap();
		end
		drain();
	endtask

	initial begin
		box_t b;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, touching boxes, all-zero box, equal scores, malformed
		send_box('{cls: 8'd0, score: 16'hFFFF, max_y: 12'd100, max_x: 12'd100,
			min_y: 12'd0, min_x: 12'd0}, 0);
		send_box('{cls: 8'd0, score: 16'd1000, max_y: 12'd100, max_x: 12'd110,
			min_y: 12'd0, min_x: 12'd10}, 0);
		send_box('{cls: 8'd0, score: 16'd1000, max_y: 12'd100, max_x: 12'd200,
			min_y: 12'd0, min_x: 12'd100}, 0);
		send_box('0, 0);
		send_box('{cls: 8'hFF, score: 16'd0, max_y: 12'hFFF, max_x: 12'hFFF,
			min_y: 12'd0, min_x: 12'd0}, 0);
		send_box('{cls: 8'hFF, score: 16'd5, max_y: 12'hFFF, max_x: 12'hFFF,
			min_y: 12'd1, min_x: 12'd1}, 0);
		send_box('{cls: 8'hFF, score: 16'd7, max_y: 12'd0, max_x: 12'd0,
			min_y: 12'hFFF, min_x: 12'hFFF}, 0);
		send_box('{cls: 8'h55, score: 16'hAAAA, max_y: 12'hAAA, max_x: 12'h555,
			min_y: 12'h555, min_x: 12'hAAA}, 1);
		drain();
		// empty frame: only an all-zero box
		send_box('0, 1);
		drain();
		write_thr(THR_W'(0));
		random_frame(6);
		write_thr(7'd127);
		random_frame(6);
		write_thr(7'd100);
		random_frame(5);
		// full store: 66 boxes, the last two dropped
		write_thr(7'd30);
		for (int i = 0; i < 66; i++) begin
			b = rand_box(3, 1000, 1000);
			send_box(b, i == 65);
		end
		drain();

		// long hold-off: frame outputs back up while the next frame waits
		write_thr(7'd50);
		hold_off = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			begin
				for (int i = 0; i < 20; i++) send_box(rand_box(2, 500, 500), i == 19);
				for (int i = 0; i < 4; i++) send_box(rand_box(2, 500, 500), i == 3);
				in_valid <= 0;
			end
		join
		drain();

		for (int f = 0; f < 45; f++) begin
			if (f % 9 == 0) write_thr(THR_W'($urandom_range(127)));
			stall_pct = (f % 5 == 0) ? 0 : $urandom_range(10, 60);
			random_frame($urandom_range(1, 12));
		end

		in_valid <= 0;
		drain();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
